// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

// File: hdl/i2csr_pkg.sv
// Package: types, constants and register codes of the I2C sensor reader.
package i2csr_pkg;

   localparam int unsigned WAIT_WIDTH = 20;

   localparam logic [WAIT_WIDTH-1:0] DATA_SETUP_TICKS = 20'd2;
   localparam logic [WAIT_WIDTH-1:0] PHASE_HOLD_TICKS = 20'd5;
   localparam logic [WAIT_WIDTH-1:0] WAIT_MAX         = 20'hFFFFF;

   localparam logic [15:0] RAW_MASK    = 16'hFFFC;
   localparam logic [14:0] TEMP_FACTOR = 15'd17572;
   localparam logic [15:0] TEMP_OFFSET = 16'd4685;
   localparam logic [14:0] HUM_FACTOR  = 15'd12500;
   localparam logic [15:0] HUM_OFFSET  = 16'd600;

   localparam logic [2:0] CSR_DEVICE_WRITE_ADDRESS   = 3'd0;
   localparam logic [2:0] CSR_TEMPERATURE_COMMAND    = 3'd1;
   localparam logic [2:0] CSR_TEMPERATURE_WAIT_TICKS = 3'd2;
   localparam logic [2:0] CSR_HUMIDITY_WAIT_TICKS    = 3'd3;
   localparam logic [2:0] CSR_ACK_TIMEOUT_TICKS      = 3'd4;

   localparam logic [7:0]            RESET_DEVICE_WRITE_ADDRESS   = 8'd128;
   localparam logic [7:0]            RESET_TEMPERATURE_COMMAND    = 8'd243;
   localparam logic [WAIT_WIDTH-1:0] RESET_TEMPERATURE_WAIT_TICKS = 20'd85000;
   localparam logic [WAIT_WIDTH-1:0] RESET_HUMIDITY_WAIT_TICKS    = 20'd30000;
   localparam logic [7:0]            RESET_ACK_TIMEOUT_TICKS      = 8'd200;

   typedef enum logic [16:0] {
      PH_IDLE      = 17'h00001,
      PH_START_A   = 17'h00002,
      PH_START_B   = 17'h00004,
      PH_START_C   = 17'h00008,
      PH_TX_SETUP  = 17'h00010,
      PH_TX_HIGH   = 17'h00020,
      PH_ACK_LOW   = 17'h00040,
      PH_ACK_HIGH  = 17'h00080,
      PH_ACK_POLL  = 17'h00100,
      PH_STOP_A    = 17'h00200,
      PH_STOP_B    = 17'h00400,
      PH_STOP_C    = 17'h00800,
      PH_MEAS_WAIT = 17'h01000,
      PH_RX_LOW    = 17'h02000,
      PH_RX_HIGH   = 17'h04000,
      PH_MACK_A    = 17'h08000,
      PH_MACK_B    = 17'h10000
   } phase_type;

   typedef enum logic [1:0] {
      NEXT_WAIT = 2'd0,
      NEXT_OK   = 2'd1,
      NEXT_ERR  = 2'd2
   } stop_next_type;

   typedef struct packed {
      logic [7:0]            device_write_address;
      logic [7:0]            temperature_command;
      logic [WAIT_WIDTH-1:0] temperature_wait_ticks;
      logic [WAIT_WIDTH-1:0] humidity_wait_ticks;
      logic [7:0]            ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_released;
      logic        busy_res;
      logic        done_res;
      logic        error;
      logic        is_temperature;
      logic [15:0] raw_reading;
   } seq_out_type;

   typedef struct packed {
      logic               scl_level;
      logic               sda_released;
      logic               busy_res;
      logic               done_res;
      logic               error;
      logic               is_temperature;
      logic [15:0]        raw_reading;
      logic signed [14:0] scaled_reading;
   } rsp_payload_type;

endpackage

// File: hdl/i2csr_sequencer.sv
// Bus sequencer: phase machine, counters and shift register for one measurement.
module i2csr_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  tick,
   input  logic                  start_request,
   input  logic [7:0]            command,
   input  logic                  sda_sample,
   input  i2csr_pkg::cfg_type    cfg,
   output i2csr_pkg::seq_out_type result
);

   i2csr_pkg::phase_type     phase_ff, phase_in;
   i2csr_pkg::stop_next_type stop_next_ff, stop_next_in;
   logic [19:0] wait_counter_ff, wait_counter_in;
   logic [7:0]  ack_poll_ff, ack_poll_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic        clock_line_ff, clock_line_in;
   logic        data_line_ff, data_line_in;
   logic        done;
   logic        err;

   logic [19:0] wc_inc;
   logic [19:0] meas_target;
   logic        hold_phase;
   logic        hold_setup;
   logic        hold_meas;
   logic        temp_sel;
   logic [3:0]  bit_inc;

   assign wc_inc      = (wait_counter_ff < i2csr_pkg::WAIT_MAX) ?
                        wait_counter_ff + 20'd1 : wait_counter_ff;
   assign temp_sel    = (held_command_ff == cfg.temperature_command);
   assign meas_target = temp_sel ? cfg.temperature_wait_ticks : cfg.humidity_wait_ticks;
   assign hold_phase  = (wc_inc >= i2csr_pkg::PHASE_HOLD_TICKS);
   assign hold_setup  = (wc_inc >= i2csr_pkg::DATA_SETUP_TICKS);
   assign hold_meas   = (wc_inc >= meas_target);
   assign bit_inc     = bit_index_ff + 4'd1;

   always_comb begin
      phase_in        = phase_ff;
      stop_next_in    = stop_next_ff;
      wait_counter_in = wait_counter_ff;
      ack_poll_in     = ack_poll_ff;
      bit_index_in    = bit_index_ff;
      byte_index_in   = byte_index_ff;
      shift_byte_in   = shift_byte_ff;
      held_command_in = held_command_ff;
      high_byte_in    = high_byte_ff;
      low_byte_in     = low_byte_ff;
      clock_line_in   = clock_line_ff;
      data_line_in    = data_line_ff;
      done            = 1'b0;
      err             = 1'b0;
      if (phase_ff == i2csr_pkg::PH_IDLE) begin
         if (start_request) begin
            held_command_in = command;
            byte_index_in   = 2'd0;
            bit_index_in    = 4'd0;
            stop_next_in    = i2csr_pkg::NEXT_WAIT;
            phase_in        = i2csr_pkg::PH_START_A;
            clock_line_in   = 1'b1;
            data_line_in    = 1'b1;
            wait_counter_in = '0;
         end
      end else if (tick) begin
         case (phase_ff)
            i2csr_pkg::PH_START_A: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  phase_in        = i2csr_pkg::PH_START_B;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b0;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_START_B: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  phase_in        = i2csr_pkg::PH_START_C;
                  clock_line_in   = 1'b0;
                  data_line_in    = 1'b0;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_START_C: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  shift_byte_in   = (byte_index_ff == 2'd2) ?
                                    cfg.device_write_address + 8'd1 :
                                    cfg.device_write_address;
                  bit_index_in    = 4'd0;
                  phase_in        = i2csr_pkg::PH_TX_SETUP;
                  clock_line_in   = 1'b0;
                  data_line_in    = shift_byte_in[7];
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_TX_SETUP: begin
               wait_counter_in = wc_inc;
               if (hold_setup) begin
                  phase_in        = i2csr_pkg::PH_TX_HIGH;
                  clock_line_in   = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_TX_HIGH: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  shift_byte_in   = {shift_byte_ff[6:0], 1'b0};
                  bit_index_in    = bit_inc;
                  wait_counter_in = '0;
                  clock_line_in   = 1'b0;
                  if (bit_inc >= 4'd8) begin
                     phase_in     = i2csr_pkg::PH_ACK_LOW;
                     data_line_in = 1'b1;
                  end else begin
                     phase_in     = i2csr_pkg::PH_TX_SETUP;
                     data_line_in = shift_byte_ff[6];
                  end
               end
            end
            i2csr_pkg::PH_ACK_LOW: begin
               wait_counter_in = wc_inc;
               if (hold_setup) begin
                  phase_in        = i2csr_pkg::PH_ACK_HIGH;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_ACK_HIGH: begin
               wait_counter_in = wc_inc;
               if (hold_setup) begin
                  ack_poll_in     = 8'd0;
                  phase_in        = i2csr_pkg::PH_ACK_POLL;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_ACK_POLL: begin
               if (!sda_sample) begin
                  wait_counter_in = '0;
                  clock_line_in   = 1'b0;
                  if (byte_index_ff == 2'd0) begin
                     byte_index_in = 2'd1;
                     shift_byte_in = held_command_ff;
                     bit_index_in  = 4'd0;
                     phase_in      = i2csr_pkg::PH_TX_SETUP;
                     data_line_in  = held_command_ff[7];
                  end else if (byte_index_ff == 2'd1) begin
                     stop_next_in  = i2csr_pkg::NEXT_WAIT;
                     phase_in      = i2csr_pkg::PH_STOP_A;
                     data_line_in  = 1'b0;
                  end else begin
                     byte_index_in = 2'd0;
                     bit_index_in  = 4'd0;
                     shift_byte_in = 8'd0;
                     phase_in      = i2csr_pkg::PH_RX_LOW;
                     data_line_in  = 1'b1;
                  end
               end else if (ack_poll_ff >= cfg.ack_timeout_ticks) begin
                  stop_next_in    = i2csr_pkg::NEXT_ERR;
                  phase_in        = i2csr_pkg::PH_STOP_A;
                  clock_line_in   = 1'b0;
                  data_line_in    = 1'b0;
                  wait_counter_in = '0;
               end else begin
                  ack_poll_in = ack_poll_ff + 8'd1;
               end
            end
            i2csr_pkg::PH_STOP_A: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  phase_in        = i2csr_pkg::PH_STOP_B;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b0;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_STOP_B: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  phase_in        = i2csr_pkg::PH_STOP_C;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_STOP_C: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
                  if (stop_next_ff == i2csr_pkg::NEXT_WAIT) begin
                     byte_index_in = 2'd2;
                     phase_in      = i2csr_pkg::PH_MEAS_WAIT;
                  end else begin
                     phase_in = i2csr_pkg::PH_IDLE;
                     done     = 1'b1;
                     err      = (stop_next_ff == i2csr_pkg::NEXT_ERR);
                  end
               end
            end
            i2csr_pkg::PH_MEAS_WAIT: begin
               wait_counter_in = wc_inc;
               if (hold_meas) begin
                  phase_in        = i2csr_pkg::PH_START_A;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_RX_LOW: begin
               wait_counter_in = wc_inc;
               if (hold_setup) begin
                  phase_in        = i2csr_pkg::PH_RX_HIGH;
                  clock_line_in   = 1'b1;
                  data_line_in    = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_RX_HIGH: begin
               if (wait_counter_ff == 20'd0) begin
                  shift_byte_in = {shift_byte_ff[6:0], sda_sample};
               end
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  bit_index_in    = bit_inc;
                  clock_line_in   = 1'b0;
                  wait_counter_in = '0;
                  if (bit_inc >= 4'd8) begin
                     phase_in     = i2csr_pkg::PH_MACK_A;
                     data_line_in = (byte_index_ff >= 2'd2);
                  end else begin
                     phase_in     = i2csr_pkg::PH_RX_LOW;
                     data_line_in = 1'b1;
                  end
               end
            end
            i2csr_pkg::PH_MACK_A: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  phase_in        = i2csr_pkg::PH_MACK_B;
                  clock_line_in   = 1'b1;
                  wait_counter_in = '0;
               end
            end
            i2csr_pkg::PH_MACK_B: begin
               wait_counter_in = wc_inc;
               if (hold_phase) begin
                  if (byte_index_ff == 2'd0) begin
                     high_byte_in = shift_byte_ff;
                  end else if (byte_index_ff == 2'd1) begin
                     low_byte_in = shift_byte_ff;
                  end
                  clock_line_in   = 1'b0;
                  wait_counter_in = '0;
                  if (byte_index_ff >= 2'd2) begin
                     stop_next_in = i2csr_pkg::NEXT_OK;
                     phase_in     = i2csr_pkg::PH_STOP_A;
                     data_line_in = 1'b0;
                  end else begin
                     byte_index_in = byte_index_ff + 2'd1;
                     bit_index_in  = 4'd0;
                     shift_byte_in = 8'd0;
                     phase_in      = i2csr_pkg::PH_RX_LOW;
                     data_line_in  = 1'b1;
                  end
               end
            end
            default: begin
               phase_in        = i2csr_pkg::PH_IDLE;
               clock_line_in   = 1'b1;
               data_line_in    = 1'b1;
               wait_counter_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      result.scl_level      = clock_line_in;
      result.sda_released   = data_line_in;
      result.busy_res       = (phase_in != i2csr_pkg::PH_IDLE);
      result.done_res       = done;
      result.error          = err;
      result.is_temperature = done && temp_sel;
      result.raw_reading    = (done && !err) ?
                              ({high_byte_ff, low_byte_ff} & i2csr_pkg::RAW_MASK) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= i2csr_pkg::PH_IDLE;
         stop_next_ff    <= i2csr_pkg::NEXT_WAIT;
         wait_counter_ff <= '0;
         ack_poll_ff     <= '0;
         bit_index_ff    <= '0;
         byte_index_ff   <= '0;
         shift_byte_ff   <= '0;
         held_command_ff <= '0;
         high_byte_ff    <= '0;
         low_byte_ff     <= '0;
         clock_line_ff   <= 1'b1;
         data_line_ff    <= 1'b1;
      end else if (step) begin
         phase_ff        <= phase_in;
         stop_next_ff    <= stop_next_in;
         wait_counter_ff <= wait_counter_in;
         ack_poll_ff     <= ack_poll_in;
         bit_index_ff    <= bit_index_in;
         byte_index_ff   <= byte_index_in;
         shift_byte_ff   <= shift_byte_in;
         held_command_ff <= held_command_in;
         high_byte_ff    <= high_byte_in;
         low_byte_ff     <= low_byte_in;
         clock_line_ff   <= clock_line_in;
         data_line_ff    <= data_line_in;
      end
   end

endmodule

// File: hdl/i2csr_scaler.sv
// Reading conversion: raw sensor word to hundredths of a degree or percent.
module i2csr_scaler (
   input  logic               valid_reading,
   input  logic               is_temperature,
   input  logic [15:0]        raw_reading,
   output logic signed [14:0] scaled_reading
);

   logic [14:0] factor;
   logic [15:0] offset;
   logic [30:0] product;
   logic [15:0] difference;

   assign factor     = is_temperature ? i2csr_pkg::TEMP_FACTOR : i2csr_pkg::HUM_FACTOR;
   assign offset     = is_temperature ? i2csr_pkg::TEMP_OFFSET : i2csr_pkg::HUM_OFFSET;
   assign product    = 31'(factor) * 31'(raw_reading);
   assign difference = {1'b0, product[30:16]} - offset;

   assign scaled_reading = valid_reading ? signed'(difference[14:0]) : 15'sd0;

endmodule

// File: hdl/i2csr_out_skid.sv
// Two-entry output stage: result register plus skid register.
module i2csr_out_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_take,
   input  i2csr_pkg::rsp_payload_type  in_data,
   output logic                        in_full,
   output logic                        out_valid,
   input  logic                        out_stall,
   output i2csr_pkg::rsp_payload_type  out_data
);

   logic                       main_valid_ff, main_valid_in;
   logic                       skid_valid_ff, skid_valid_in;
   i2csr_pkg::rsp_payload_type main_data_ff, main_data_in;
   i2csr_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                       main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         main_valid_in = skid_valid_ff || in_take;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_full   = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// File: hdl/i2c_sensor_measurement_reader.sv
// Top level of the I2C sensor measurement reader.
// Each accepted transaction is one step of the bus sequencer (one microsecond
// tick or a start request) and yields exactly one result transaction from the
// output register, passing through the skid register first when the result
// side stalls. A transaction can be accepted in every cycle in which req_stall
// is low: the next state of the phase machine and counters and the conversion
// multiplier are combinational, and a two-entry output stage raises req_stall
// only when both the result and the skid register hold results not yet taken.
// Configuration writes take effect on the next step.
module i2c_sensor_measurement_reader (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_tick,
   input  logic               req_start_request,
   input  logic [7:0]         req_command,
   input  logic               req_sda_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_scl_level,
   output logic               rsp_sda_released,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic               rsp_error,
   output logic               rsp_is_temperature,
   output logic [15:0]        rsp_raw_reading,
   output logic signed [14:0] rsp_scaled_reading,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_write_data
);

   i2csr_pkg::cfg_type         cfg_ff, cfg_in;
   i2csr_pkg::seq_out_type     seq_result;
   i2csr_pkg::rsp_payload_type rsp_data;
   i2csr_pkg::rsp_payload_type out_data;
   logic signed [14:0]         scaled;
   logic                       step;
   logic                       skid_full;

   assign step      = req_valid && !skid_full;
   assign req_stall = skid_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            i2csr_pkg::CSR_DEVICE_WRITE_ADDRESS:
               cfg_in.device_write_address = csr_write_data[7:0];
            i2csr_pkg::CSR_TEMPERATURE_COMMAND:
               cfg_in.temperature_command = csr_write_data[7:0];
            i2csr_pkg::CSR_TEMPERATURE_WAIT_TICKS:
               cfg_in.temperature_wait_ticks = csr_write_data;
            i2csr_pkg::CSR_HUMIDITY_WAIT_TICKS:
               cfg_in.humidity_wait_ticks = csr_write_data;
            i2csr_pkg::CSR_ACK_TIMEOUT_TICKS:
               cfg_in.ack_timeout_ticks = csr_write_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_write_address   <= i2csr_pkg::RESET_DEVICE_WRITE_ADDRESS;
         cfg_ff.temperature_command    <= i2csr_pkg::RESET_TEMPERATURE_COMMAND;
         cfg_ff.temperature_wait_ticks <= i2csr_pkg::RESET_TEMPERATURE_WAIT_TICKS;
         cfg_ff.humidity_wait_ticks    <= i2csr_pkg::RESET_HUMIDITY_WAIT_TICKS;
         cfg_ff.ack_timeout_ticks      <= i2csr_pkg::RESET_ACK_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2csr_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .tick          (req_tick),
      .start_request (req_start_request),
      .command       (req_command),
      .sda_sample    (req_sda_sample),
      .cfg           (cfg_ff),
      .result        (seq_result)
   );

   i2csr_scaler u_scaler (
      .valid_reading  (seq_result.done_res && !seq_result.error),
      .is_temperature (seq_result.is_temperature),
      .raw_reading    (seq_result.raw_reading),
      .scaled_reading (scaled)
   );

   always_comb begin
      rsp_data.scl_level      = seq_result.scl_level;
      rsp_data.sda_released   = seq_result.sda_released;
      rsp_data.busy_res       = seq_result.busy_res;
      rsp_data.done_res       = seq_result.done_res;
      rsp_data.error          = seq_result.error;
      rsp_data.is_temperature = seq_result.is_temperature;
      rsp_data.raw_reading    = seq_result.raw_reading;
      rsp_data.scaled_reading = scaled;
   end

   i2csr_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_take   (step),
      .in_data   (rsp_data),
      .in_full   (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_scl_level      = out_data.scl_level;
   assign rsp_sda_released   = out_data.sda_released;
   assign rsp_busy_res       = out_data.busy_res;
   assign rsp_done_res       = out_data.done_res;
   assign rsp_error          = out_data.error;
   assign rsp_is_temperature = out_data.is_temperature;
   assign rsp_raw_reading    = out_data.raw_reading;
   assign rsp_scaled_reading = out_data.scaled_reading;

endmodule

// File: hdl/i2csr_checker.sv
// Port-level checker for the I2C sensor measurement reader, with its bind.
`include "assert_macros.svh"

module i2csr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_scl_level,
   input logic               rsp_sda_released,
   input logic               rsp_busy_res,
   input logic               rsp_done_res,
   input logic               rsp_error,
   input logic               rsp_is_temperature,
   input logic [15:0]        rsp_raw_reading,
   input logic signed [14:0] rsp_scaled_reading
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
             rsp_valid && $stable({rsp_done_res, rsp_raw_reading, rsp_scaled_reading}))
   `CHK_IMPLY(a_stall_needs_result, clock, reset, req_stall, rsp_valid)
   `CHK_IMPLY(a_done_ends_busy, clock, reset, rsp_valid && rsp_done_res,
              !rsp_busy_res && rsp_scl_level && rsp_sda_released)
   `CHK_IMPLY(a_error_clears_reading, clock, reset, rsp_valid && rsp_error,
              rsp_done_res && rsp_raw_reading == 16'd0 && rsp_scaled_reading == 15'sd0)
   `CHK_IMPLY(a_idle_fields_zero, clock, reset, rsp_valid && !rsp_done_res,
              !rsp_is_temperature && rsp_raw_reading == 16'd0)

endmodule

bind i2c_sensor_measurement_reader i2csr_checker u_i2csr_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the I2C sensor reader: directed and random tick streams vs. a bus model.
`timescale 1ns / 100ps

module tb_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   localparam logic [19:0] HOLD_TICKS  = i2csr_pkg::PHASE_HOLD_TICKS;
   localparam logic [19:0] SETUP_TICKS = i2csr_pkg::DATA_SETUP_TICKS;

   typedef struct packed {
      logic       tick;
      logic       start_request;
      logic [7:0] command;
      logic       sda_sample;
   } tick_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_tick = 1'b0;
   logic               req_start_request = 1'b0;
   logic [7:0]         req_command = 8'd0;
   logic               req_sda_sample = 1'b1;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_scl_level;
   logic               rsp_sda_released;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic               rsp_error;
   logic               rsp_is_temperature;
   logic [15:0]        rsp_raw_reading;
   logic signed [14:0] rsp_scaled_reading;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = i2csr_pkg::CSR_DEVICE_WRITE_ADDRESS;
   logic [19:0]        csr_write_data = 20'd0;

   i2c_sensor_measurement_reader dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_tick           (req_tick),
      .req_start_request  (req_start_request),
      .req_command        (req_command),
      .req_sda_sample     (req_sda_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scl_level      (rsp_scl_level),
      .rsp_sda_released   (rsp_sda_released),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_error          (rsp_error),
      .rsp_is_temperature (rsp_is_temperature),
      .rsp_raw_reading    (rsp_raw_reading),
      .rsp_scaled_reading (rsp_scaled_reading),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   i2csr_pkg::phase_type     ph;
   logic [19:0]              hold_cnt;
   logic [7:0]               poll_cnt;
   logic [3:0]               bit_cnt;
   logic [1:0]               byte_cnt;
   logic [7:0]               shreg;
   logic [7:0]               cmd_q;
   logic [7:0]               msb_q;
   logic [7:0]               lsb_q;
   logic                     scl_q;
   logic                     sda_q;
   i2csr_pkg::stop_next_type after_stop;
   i2csr_pkg::cfg_type       cfg;

   int  done_total = 0;
   int  items_sent = 0;
   int  mismatches = 0;
   int  quiet = 0;
   int  ack_pct = 0;
   int  ack_delay = 0;
   bit  nack_plan = 1'b1;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;

   i2csr_pkg::rsp_payload_type due_outputs[$];
   tick_item_type              dir_items[$];
   i2csr_pkg::rsp_payload_type dir_expect[$];
   bit                         dir_typed[$];

   function automatic void reset_model();
      ph         = i2csr_pkg::PH_IDLE;
      hold_cnt   = '0;
      poll_cnt   = '0;
      bit_cnt    = '0;
      byte_cnt   = '0;
      shreg      = '0;
      cmd_q      = '0;
      msb_q      = '0;
      lsb_q      = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      after_stop = i2csr_pkg::NEXT_WAIT;
      cfg.device_write_address   = i2csr_pkg::RESET_DEVICE_WRITE_ADDRESS;
      cfg.temperature_command    = i2csr_pkg::RESET_TEMPERATURE_COMMAND;
      cfg.temperature_wait_ticks = i2csr_pkg::RESET_TEMPERATURE_WAIT_TICKS;
      cfg.humidity_wait_ticks    = i2csr_pkg::RESET_HUMIDITY_WAIT_TICKS;
      cfg.ack_timeout_ticks      = i2csr_pkg::RESET_ACK_TIMEOUT_TICKS;
   endfunction

   function automatic void enter(input i2csr_pkg::phase_type p, input logic scl,
                                 input logic sda);
      ph       = p;
      scl_q    = scl;
      sda_q    = sda;
      hold_cnt = '0;
   endfunction

   function automatic bit hold_done(input logic [19:0] n);
      if (hold_cnt < i2csr_pkg::WAIT_MAX)
         hold_cnt = hold_cnt + 20'd1;
      return hold_cnt >= n;
   endfunction

   function automatic i2csr_pkg::rsp_payload_type sequencer_step(input tick_item_type it);
      i2csr_pkg::rsp_payload_type res;
      logic [15:0]                raw;
      logic [31:0]                prod;
      int                         s;
      bit                         done;
      bit                         failed;
      res    = '0;
      done   = 1'b0;
      failed = 1'b0;
      if (ph == i2csr_pkg::PH_IDLE) begin
         if (it.start_request) begin
            cmd_q      = it.command;
            byte_cnt   = 2'd0;
            bit_cnt    = 4'd0;
            after_stop = i2csr_pkg::NEXT_WAIT;
            enter(i2csr_pkg::PH_START_A, 1'b1, 1'b1);
         end
      end else if (it.tick) begin
         case (ph)
            i2csr_pkg::PH_START_A:
               if (hold_done(HOLD_TICKS)) enter(i2csr_pkg::PH_START_B, 1'b1, 1'b0);
            i2csr_pkg::PH_START_B:
               if (hold_done(HOLD_TICKS)) enter(i2csr_pkg::PH_START_C, 1'b0, 1'b0);
            i2csr_pkg::PH_START_C: if (hold_done(HOLD_TICKS)) begin
               shreg = (byte_cnt == 2'd2) ? cfg.device_write_address + 8'd1
                                          : cfg.device_write_address;
               bit_cnt = 4'd0;
               enter(i2csr_pkg::PH_TX_SETUP, 1'b0, shreg[7]);
            end
            i2csr_pkg::PH_TX_SETUP:
               if (hold_done(SETUP_TICKS)) enter(i2csr_pkg::PH_TX_HIGH, 1'b1, sda_q);
            i2csr_pkg::PH_TX_HIGH: if (hold_done(HOLD_TICKS)) begin
               shreg   = shreg << 1;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) enter(i2csr_pkg::PH_ACK_LOW, 1'b0, 1'b1);
               else enter(i2csr_pkg::PH_TX_SETUP, 1'b0, shreg[7]);
            end
            i2csr_pkg::PH_ACK_LOW:
               if (hold_done(SETUP_TICKS)) enter(i2csr_pkg::PH_ACK_HIGH, 1'b1, 1'b1);
            i2csr_pkg::PH_ACK_HIGH: if (hold_done(SETUP_TICKS)) begin
               poll_cnt = 8'd0;
               enter(i2csr_pkg::PH_ACK_POLL, 1'b1, 1'b1);
            end
            i2csr_pkg::PH_ACK_POLL: if (!it.sda_sample) begin
               if (byte_cnt == 2'd0) begin
                  byte_cnt = 2'd1;
                  shreg    = cmd_q;
                  bit_cnt  = 4'd0;
                  enter(i2csr_pkg::PH_TX_SETUP, 1'b0, shreg[7]);
               end else if (byte_cnt == 2'd1) begin
                  after_stop = i2csr_pkg::NEXT_WAIT;
                  enter(i2csr_pkg::PH_STOP_A, 1'b0, 1'b0);
               end else begin
                  byte_cnt = 2'd0;
                  bit_cnt  = 4'd0;
                  shreg    = 8'd0;
                  enter(i2csr_pkg::PH_RX_LOW, 1'b0, 1'b1);
               end
            end else if (poll_cnt >= cfg.ack_timeout_ticks) begin
               after_stop = i2csr_pkg::NEXT_ERR;
               enter(i2csr_pkg::PH_STOP_A, 1'b0, 1'b0);
            end else begin
               poll_cnt = poll_cnt + 8'd1;
            end
            i2csr_pkg::PH_STOP_A:
               if (hold_done(HOLD_TICKS)) enter(i2csr_pkg::PH_STOP_B, 1'b1, 1'b0);
            i2csr_pkg::PH_STOP_B:
               if (hold_done(HOLD_TICKS)) enter(i2csr_pkg::PH_STOP_C, 1'b1, 1'b1);
            i2csr_pkg::PH_STOP_C: if (hold_done(HOLD_TICKS)) begin
               if (after_stop == i2csr_pkg::NEXT_WAIT) begin
                  byte_cnt = 2'd2;
                  enter(i2csr_pkg::PH_MEAS_WAIT, 1'b1, 1'b1);
               end else begin
                  enter(i2csr_pkg::PH_IDLE, 1'b1, 1'b1);
                  done   = 1'b1;
                  failed = (after_stop == i2csr_pkg::NEXT_ERR);
               end
            end
            i2csr_pkg::PH_MEAS_WAIT: begin
               if (hold_done((cmd_q == cfg.temperature_command) ? cfg.temperature_wait_ticks
                                                                : cfg.humidity_wait_ticks))
                  enter(i2csr_pkg::PH_START_A, 1'b1, 1'b1);
            end
            i2csr_pkg::PH_RX_LOW:
               if (hold_done(SETUP_TICKS)) enter(i2csr_pkg::PH_RX_HIGH, 1'b1, 1'b1);
            i2csr_pkg::PH_RX_HIGH: begin
               if (hold_cnt == 20'd0)
                  shreg = {shreg[6:0], it.sda_sample};
               if (hold_done(HOLD_TICKS)) begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= 4'd8) enter(i2csr_pkg::PH_MACK_A, 1'b0, byte_cnt >= 2'd2);
                  else enter(i2csr_pkg::PH_RX_LOW, 1'b0, 1'b1);
               end
            end
            i2csr_pkg::PH_MACK_A:
               if (hold_done(HOLD_TICKS)) enter(i2csr_pkg::PH_MACK_B, 1'b1, sda_q);
            i2csr_pkg::PH_MACK_B: if (hold_done(HOLD_TICKS)) begin
               if (byte_cnt == 2'd0) msb_q = shreg;
               else if (byte_cnt == 2'd1) lsb_q = shreg;
               if (byte_cnt >= 2'd2) begin
                  after_stop = i2csr_pkg::NEXT_OK;
                  enter(i2csr_pkg::PH_STOP_A, 1'b0, 1'b0);
               end else begin
                  byte_cnt = byte_cnt + 2'd1;
                  bit_cnt  = 4'd0;
                  shreg    = 8'd0;
                  enter(i2csr_pkg::PH_RX_LOW, 1'b0, 1'b1);
               end
            end
            default: enter(i2csr_pkg::PH_IDLE, 1'b1, 1'b1);
         endcase
      end

      if (done) begin
         done_total         = done_total + 1;
         res.done_res       = 1'b1;
         res.error          = failed;
         res.is_temperature = (cmd_q == cfg.temperature_command);
         if (!failed) begin
            raw = {msb_q, lsb_q} & i2csr_pkg::RAW_MASK;
            if (res.is_temperature) begin
               prod = 32'(i2csr_pkg::TEMP_FACTOR) * 32'(raw);
               s    = int'(prod[31:16]) - int'(i2csr_pkg::TEMP_OFFSET);
            end else begin
               prod = 32'(i2csr_pkg::HUM_FACTOR) * 32'(raw);
               s    = int'(prod[31:16]) - int'(i2csr_pkg::HUM_OFFSET);
            end
            res.raw_reading    = raw;
            res.scaled_reading = 15'(s);
         end
      end
      res.scl_level    = scl_q;
      res.sda_released = sda_q;
      res.busy_res     = (ph != i2csr_pkg::PH_IDLE);
      return res;
   endfunction

   function automatic tick_item_type next_item(input bit allow_start);
      tick_item_type it;
      int            lim;
      it.tick = ($urandom_range(0, 99) < 95);
      if (ph == i2csr_pkg::PH_IDLE)
         it.start_request = allow_start && ($urandom_range(0, 1) == 1);
      else
         it.start_request = ($urandom_range(0, 9) == 0);
      it.command    = ($urandom_range(0, 1) == 1) ? cfg.temperature_command : 8'($urandom);
      it.sda_sample = 1'($urandom_range(0, 1));
      if (ph == i2csr_pkg::PH_ACK_POLL) begin
         it.sda_sample = nack_plan || (poll_cnt < ack_delay);
      end else begin
         nack_plan = ($urandom_range(0, 99) >= ack_pct);
         lim       = (cfg.ack_timeout_ticks < 3) ? cfg.ack_timeout_ticks : 3;
         ack_delay = ($urandom_range(0, 3) == 0) ? cfg.ack_timeout_ticks
                                                 : $urandom_range(0, lim);
      end
      return it;
   endfunction

   task automatic add_row(input logic tk, input logic st, input logic [7:0] cmd,
                          input logic sd, input bit typed, input logic scl,
                          input logic sda, input logic busy);
      tick_item_type              it;
      i2csr_pkg::rsp_payload_type e;
      it.tick          = tk;
      it.start_request = st;
      it.command       = cmd;
      it.sda_sample    = sd;
      e                = '0;
      e.scl_level      = scl;
      e.sda_released   = sda;
      e.busy_res       = busy;
      dir_items.push_back(it);
      dir_expect.push_back(e);
      dir_typed.push_back(typed);
   endtask

   task automatic send_item(input tick_item_type it, input bit typed,
                            input i2csr_pkg::rsp_payload_type typed_exp);
      int                         gap;
      i2csr_pkg::rsp_payload_type predicted;
      if ($urandom_range(0, 49) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_tick          <= it.tick;
      req_start_request <= it.start_request;
      req_command       <= it.command;
      req_sda_sample    <= it.sda_sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = sequencer_step(it);
      due_outputs.push_back(typed ? typed_exp : predicted);
      items_sent = items_sent + 1;
   endtask

   task automatic quiesce();
      @(negedge clock) req_valid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic random_step(input bit allow_start);
      if (items_sent == 200 || $urandom_range(0, 299) == 0)
         quiesce();
      send_item(next_item(allow_start), 1'b0, '0);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [19:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] addr, input logic [7:0] temp_cmd,
                                 input logic [19:0] temp_wait, input logic [19:0] hum_wait,
                                 input logic [7:0] timeout_ticks);
      quiesce();
      repeat (4) @(posedge clock);
      write_csr(i2csr_pkg::CSR_DEVICE_WRITE_ADDRESS, 20'(addr));
      write_csr(i2csr_pkg::CSR_TEMPERATURE_COMMAND, 20'(temp_cmd));
      write_csr(i2csr_pkg::CSR_TEMPERATURE_WAIT_TICKS, temp_wait);
      write_csr(i2csr_pkg::CSR_HUMIDITY_WAIT_TICKS, hum_wait);
      write_csr(i2csr_pkg::CSR_ACK_TIMEOUT_TICKS, 20'(timeout_ticks));
      cfg.device_write_address   = addr;
      cfg.temperature_command    = temp_cmd;
      cfg.temperature_wait_ticks = temp_wait;
      cfg.humidity_wait_ticks    = hum_wait;
      cfg.ack_timeout_ticks      = timeout_ticks;
   endtask

   task automatic run_phase(input int pct, input int target);
      int start_count;
      ack_pct     = pct;
      start_count = done_total;
      while (done_total - start_count < target) random_step(1'b1);
      while (ph != i2csr_pkg::PH_IDLE) random_step(1'b0);
   endtask

   task automatic check_output();
      i2csr_pkg::rsp_payload_type got;
      i2csr_pkg::rsp_payload_type want;
      got.scl_level      = rsp_scl_level;
      got.sda_released   = rsp_sda_released;
      got.busy_res       = rsp_busy_res;
      got.done_res       = rsp_done_res;
      got.error          = rsp_error;
      got.is_temperature = rsp_is_temperature;
      got.raw_reading    = rsp_raw_reading;
      got.scaled_reading = rsp_scaled_reading;
      if (due_outputs.size() == 0) begin
         mismatches = mismatches + 1;
         if (mismatches <= REPORT_MAX)
            $display("unexpected result transaction at %0t", $realtime);
      end else begin
         want = due_outputs.pop_front();
         if (got.scl_level !== want.scl_level || got.sda_released !== want.sda_released ||
             got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
             got.error !== want.error || got.is_temperature !== want.is_temperature ||
             got.raw_reading !== want.raw_reading ||
             got.scaled_reading !== want.scaled_reading) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
               $display({"mismatch at %0t: expected scl=%b sda=%b busy=%b done=%b err=%b ",
                         "temp=%b raw=%0d scaled=%0d, got scl=%b sda=%b busy=%b done=%b ",
                         "err=%b temp=%b raw=%0d scaled=%0d"}, $realtime,
                        want.scl_level, want.sda_released, want.busy_res, want.done_res,
                        want.error, want.is_temperature, want.raw_reading,
                        want.scaled_reading, got.scl_level, got.sda_released,
                        got.busy_res, got.done_res, got.error, got.is_temperature,
                        got.raw_reading, got.scaled_reading);
         end
      end
   endtask

   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 49) == 0)
            recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_output();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int i;
      reset_model();
      add_row(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      add_row(1'b1, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      add_row(1'b0, 1'b1, 8'hF3, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      add_row(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      add_row(1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      add_row(1'b1, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b1, 8'hF3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hFE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hF3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'h0F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(1'b1, 1'b0, 8'hF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // keep the reset address and command, shorten the waits
      write_csr(i2csr_pkg::CSR_TEMPERATURE_WAIT_TICKS, 20'd3);
      write_csr(i2csr_pkg::CSR_HUMIDITY_WAIT_TICKS, 20'd0);
      write_csr(i2csr_pkg::CSR_ACK_TIMEOUT_TICKS, 20'd2);
      cfg.temperature_wait_ticks = 20'd3;
      cfg.humidity_wait_ticks    = 20'd0;
      cfg.ack_timeout_ticks      = 8'd2;

      ack_pct = 100;
      for (i = 0; i < dir_items.size(); i++)
         send_item(dir_items[i], dir_typed[i], dir_expect[i]);
      while (ph != i2csr_pkg::PH_IDLE) random_step(1'b0);

      apply_settings(8'hFE, 8'h5A, 20'd0, 20'd0, 8'd0);
      run_phase(0, 1);

      quiesce();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
